[rtl/rtdt_pkg.sv]
package rtdt_pkg;

  localparam int CODE_BITS = 15;
  localparam int RREF_W    = 20;
  localparam int R0_W      = 18;
  localparam int TEMP_W    = 20;

  // numerator c*rref << (24-CODE_BITS): 15+20+9 = 44 bits
  localparam int NUM_W  = CODE_BITS + RREF_W + (24 - CODE_BITS);
  // x in Q24, only values below 2^27 are in range
  localparam int XQ_W   = 28;
  localparam int D_W    = 59;           // radicand width (P < 2^59)
  localparam int S_W    = 30;           // root width

  localparam logic [31:0]    K_C  = 32'd2255859375;
  localparam logic [D_W-1:0] K_P  = 59'd15274808890000 * 59'd16384
                                    + 59'd2255859375 * 59'd16777216;
  localparam logic [S_W-1:0] K_AS = 30'd500262400;
  localparam logic signed [TEMP_W-1:0] T_MIN = -20'sd25000;
  localparam logic signed [TEMP_W-1:0] T_MAX = 20'sd340000;

  localparam logic [0:0] REG_RREF = 1'b0;
  localparam logic [0:0] REG_R0   = 1'b1;

endpackage

[rtl/rtdt_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
// Quotient limited to rtdt_pkg::XQ_W-1 bits; overflow flags quotient >= 2^27.
module rtdt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [rtdt_pkg::NUM_W-1:0]  num,
  input  logic [rtdt_pkg::R0_W-1:0]   den,
  output logic                        out_valid,
  output logic [rtdt_pkg::XQ_W-2:0]   quo,
  output logic                        ovf
);
  localparam int NW = rtdt_pkg::NUM_W;
  localparam int QB = rtdt_pkg::XQ_W - 1;   // 27 quotient bits
  localparam int HI = NW - QB;              // high part checked against den<<QB
  localparam int RW = rtdt_pkg::R0_W + 1;

  logic              v   [0:QB];
  logic [RW-1:0]     rem [0:QB];
  logic [NW-1:0]     nm  [0:QB];
  logic [rtdt_pkg::R0_W-1:0] dd [0:QB];
  logic [QB-1:0]     q   [0:QB];
  logic              of  [0:QB];

  // stage 0: overflow check, quotient >= 2^27 iff num[NW-1:QB] >= den
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= in_valid;
    nm[0]  <= num;
    dd[0]  <= den;
    rem[0] <= '0;
    q[0]   <= '0;
    of[0]  <= ({1'b0, num[NW-1:QB]} >= den);
  end

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic [RW-1:0] part;
    logic [RW-1:0] pre;
    logic          ge;
    // remainder below den when no overflow; start with high bits folded in at step 0
    always_comb begin
      if (i == 0) pre = {{(RW-HI){1'b0}}, nm[0][NW-1:QB]} ;
      else        pre = rem[i];
      part = (i == 0) ? pre : {pre[RW-2:0], nm[i][QB-i]};
      ge   = part >= {1'b0, dd[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else     v[i+1] <= v[i];
      nm[i+1] <= nm[i];
      dd[i+1] <= dd[i];
      of[i+1] <= of[i];
      if (i == 0) begin
        // with overflow cleared, high part < den; next stage brings in bit QB-1
        rem[i+1] <= part;
        q[i+1]   <= q[i];
      end else begin
        rem[i+1] <= ge ? part - {1'b0, dd[i]} : part;
        q[i+1]   <= {q[i][QB-2:0], ge};
      end
    end
  end

  // final bit
  logic [RW-1:0] lpart;
  logic          lge;
  assign lpart = {rem[QB][RW-2:0], nm[QB][0]};
  assign lge   = lpart >= {1'b0, dd[QB]};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v[QB];
    quo <= {q[QB][QB-2:0], lge};
    ovf <= of[QB];
  end
endmodule

[rtl/rtdt_sqrt.sv]
// Pipelined bit-pair integer square root, one result bit per stage.
module rtdt_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [rtdt_pkg::D_W-1:0]   rad,
  input  logic                       inv_in,
  output logic                       out_valid,
  output logic [rtdt_pkg::S_W-1:0]   root,
  output logic                       inv_out
);
  localparam int SW = rtdt_pkg::S_W;
  localparam int PW = 2 * SW;
  localparam int RW = SW + 2;

  logic          v   [0:SW];
  logic          iv  [0:SW];
  logic [PW-1:0] rd  [0:SW];
  logic [RW-1:0] rem [0:SW];
  logic [SW-1:0] r   [0:SW];

  always_comb begin
    v[0]   = in_valid;
    iv[0]  = inv_in;
    rd[0]  = {1'b0, rad};
    rem[0] = '0;
    r[0]   = '0;
  end

  for (genvar i = 0; i < SW; i++) begin : g_st
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;
    assign t     = {rem[i][RW-3:0], rd[i][PW-1-2*i -: 2]};
    assign trial = {r[i], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else     v[i+1] <= v[i];
      iv[i+1]  <= iv[i];
      rd[i+1]  <= rd[i];
      rem[i+1] <= ge ? t - trial : t;
      r[i+1]   <= {r[i][SW-2:0], ge};
    end
  end

  assign out_valid = v[SW];
  assign root      = r[SW];
  assign inv_out   = iv[SW];
endmodule

[rtl/rtd_code_to_temperature.sv]
// RTD ratio code to temperature, inverse Callendar-Van Dusen quadratic.
// Request channel: rtd_register_word is taken at a clock edge with start high
// and busy low. busy is always low: one request can enter every cycle.
// Result channel: temperature_centi and invalid are valid for one cycle
// while done is high; the receiver cannot stall, and none is needed.
// Pipeline order: ratio product, divider, radicand, square root, then
// scaling and output.
// Throughput is one request per cycle; the divider and root are fully
// pipelined, one quotient or root bit per stage.
// Configuration: cfg_we with cfg_index 0 writes reference_resistance,
// index 1 writes nominal_resistance (0 is taken as 1); other indexes are
// ignored. Write only while no request is in flight.
// Reset (rst, synchronous) empties the pipeline and restores the register
// defaults: 43000 and 10000 (0.01 ohm units).
// Divider overflow or a negative radicand sets invalid, temperature 340000.
module rtd_code_to_temperature (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] rtd_register_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        done,
  output logic signed [19:0] temperature_centi,
  output logic        invalid
);
  localparam int CB = rtdt_pkg::CODE_BITS;
  localparam int NW = rtdt_pkg::NUM_W;
  localparam int DW = rtdt_pkg::D_W;
  localparam int SW = rtdt_pkg::S_W;
  localparam int TEMP_W_L = rtdt_pkg::TEMP_W;

  logic [rtdt_pkg::RREF_W-1:0] reference_resistance;
  logic [rtdt_pkg::R0_W-1:0]   nominal_resistance;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_resistance <= 20'd43000;
      nominal_resistance   <= 18'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtdt_pkg::REG_RREF: reference_resistance <= cfg_data;
        rtdt_pkg::REG_R0:   nominal_resistance   <= cfg_data[rtdt_pkg::R0_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1/2: code * rref
  logic            v1, v2;
  logic [CB-1:0]   code1;
  logic [CB+rtdt_pkg::RREF_W-1:0] prod2;
  logic [rtdt_pkg::R0_W-1:0] r0_1, r0_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
    code1 <= rtd_register_word[15 -: CB];
    r0_1  <= (nominal_resistance == '0) ? rtdt_pkg::R0_W'(1) : nominal_resistance;
    prod2 <= code1 * reference_resistance;
    r0_2  <= r0_1;
  end

  logic [NW-1:0] num2;
  assign num2 = {prod2, {(24-CB){1'b0}}};

  logic                       dv;
  logic [rtdt_pkg::XQ_W-2:0]  xq;
  logic                       dovf;

  rtdt_div u_div (
    .clk(clk), .rst(rst), .in_valid(v2), .num(num2), .den(r0_2),
    .out_valid(dv), .quo(xq), .ovf(dovf)
  );

  // radicand: K_C*xq as partial products over xq[15:0] and xq[26:16]
  logic        v3, v4, v5;
  logic        o3, o4, o5;
  logic [47:0] pl3, ph3;
  logic [DW-1:0] cq4;
  logic [DW-1:0] d5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v3 <= dv; v4 <= v3; v5 <= v4;
    end
    o3  <= dovf;
    pl3 <= 48'(rtdt_pkg::K_C) * 48'(xq[15:0]);
    ph3 <= 48'(rtdt_pkg::K_C) * 48'(xq[26:16]);
    o4  <= o3;
    cq4 <= DW'(pl3) + (DW'(ph3) << 16);
    o5  <= o4 || (cq4 > rtdt_pkg::K_P);
    d5  <= rtdt_pkg::K_P - cq4;
  end

  logic          sv;
  logic [SW-1:0] s;
  logic          sinv;

  rtdt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(v5), .rad(o5 ? '0 : d5), .inv_in(o5),
    .out_valid(sv), .root(s), .inv_out(sinv)
  );

  // scaling: t = round((K_AS - s)*5 / 7392), via reciprocal multiply
  // 7392 = 32*231; divide by 231 with multiply by ceil(2^37/231),
  // exact for any dividend below 2^29.
  logic          v6, v7, v8, v9, v10, v11, v12;
  logic          i6, i7, i8, i9, i10, i11, i12;
  logic          n6, n7, n8, n9, n10, n11;
  logic [33:0]   m6;          // |n5|
  logic [33:0]   m7;          // |n5| + 3696
  logic [28:0]   a8;          // m7 >> 5
  logic [58:0]   p9;
  logic [22:0]   q10;
  logic [28:0]   a9, a10;
  logic [31:0]   r11;
  logic [22:0]   q11;
  logic signed [TEMP_W_L-1:0] t12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
    end else begin
      v6 <= sv; v7 <= v6; v8 <= v7; v9 <= v8;
      v10 <= v9; v11 <= v10; v12 <= v11;
    end
    i6 <= sinv;
    n6 <= s > rtdt_pkg::K_AS;
    m6 <= (s > rtdt_pkg::K_AS) ? 34'(s - rtdt_pkg::K_AS) * 34'd5
                              : 34'(rtdt_pkg::K_AS - s) * 34'd5;
    i7 <= i6; n7 <= n6;
    m7 <= m6 + 34'd3696;
    i8 <= i7; n8 <= n7;
    a8 <= m7[33:5];           // floor((m+3696)/7392) = floor(floor(./32)/231)
    i9 <= i8; n9 <= n8;
    p9 <= 59'(a8) * 59'd594973825;  // ceil(2^37/231)
    a9 <= a8;
    i10 <= i9; n10 <= n9;
    q10 <= 23'(p9[58:37]);
    a10 <= a9;
    i11 <= i10; n11 <= n10;
    r11 <= 32'(a10) - 32'(q10) * 32'd231;
    q11 <= q10;
    i12 <= i11;
    // one correction step
    begin
      if (r11 >= 32'd231) t12 <= n11 ? -TEMP_W_L'(q11 + 23'd1) : TEMP_W_L'(q11 + 23'd1);
      else if (r11[31])   t12 <= n11 ? -TEMP_W_L'(q11 - 23'd1) : TEMP_W_L'(q11 - 23'd1);
      else                t12 <= n11 ? -TEMP_W_L'(q11) : TEMP_W_L'(q11);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v12;
    if (i12) begin
      temperature_centi <= rtdt_pkg::T_MAX;
      invalid <= 1'b1;
    end else begin
      invalid <= 1'b0;
      if (t12 < rtdt_pkg::T_MIN)      temperature_centi <= rtdt_pkg::T_MIN;
      else if (t12 > rtdt_pkg::T_MAX) temperature_centi <= rtdt_pkg::T_MAX;
      else                            temperature_centi <= t12;
    end
  end
endmodule

[tb/tb_rtd_code_to_temperature.sv]
`timescale 1ns / 1ps

module tb_rtd_code_to_temperature;

  typedef struct packed {
    logic signed [rtdt_pkg::TEMP_W-1:0] temp;
    logic                               inv;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] rtd_register_word;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [19:0] cfg_data;
  logic        done;
  logic signed [19:0] temperature_centi;
  logic        invalid;

  rtd_code_to_temperature DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rtd_register_word(rtd_register_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .temperature_centi(temperature_centi), .invalid(invalid)
  );

  reading_t   pending_readings[$];
  logic [rtdt_pkg::RREF_W-1:0] ref_ohms;
  logic [rtdt_pkg::R0_W-1:0]   nom_ohms;
  int         errors;
  int         requests_sent;
  int         readings_seen;
  int         invalid_seen;
  int         sender_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic reading_t convert_code(logic [15:0] word);
    reading_t    r;
    logic [63:0] code, r0, xq, q, s;
    longint      n5, t;
    code = 64'(word >> (16 - rtdt_pkg::CODE_BITS));
    r0 = (nom_ohms == 0) ? 64'd1 : 64'(nom_ohms);
    xq = ((code * 64'(ref_ohms)) << (24 - rtdt_pkg::CODE_BITS)) / r0;
    r.temp = rtdt_pkg::T_MAX;
    r.inv = 1'b1;
    if (xq >= (64'd1 << 27)) return r;
    q = 64'(rtdt_pkg::K_C) * xq;
    if (q > 64'(rtdt_pkg::K_P)) return r;
    s = int_sqrt(64'(rtdt_pkg::K_P) - q);
    n5 = (longint'(rtdt_pkg::K_AS) - longint'(s)) * 5;
    if (n5 >= 0) t = (n5 + 3696) / 7392;
    else t = -((-n5 + 3696) / 7392);
    if (t < rtdt_pkg::T_MIN) t = rtdt_pkg::T_MIN;
    if (t > rtdt_pkg::T_MAX) t = rtdt_pkg::T_MAX;
    r.temp = t[rtdt_pkg::TEMP_W-1:0];
    r.inv = 1'b0;
    return r;
  endfunction

  // result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    reading_t want;
    if (!rst && done) begin
      readings_seen++;
      if (invalid) invalid_seen++;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result temp=%0d invalid=%0b",
                 $time, temperature_centi, invalid);
      end else begin
        want = pending_readings.pop_front();
        if (temperature_centi !== want.temp) begin
          errors++;
          $display("%0t: temperature_centi expected %0d actual %0d",
                   $time, want.temp, temperature_centi);
        end
        if (invalid !== want.inv) begin
          errors++;
          $display("%0t: invalid expected %0b actual %0b", $time, want.inv, invalid);
        end
      end
    end
  end

  task automatic send_request(logic [15:0] word);
    start <= 1'b1;
    rtd_register_word <= word;
    do @(posedge clk); while (busy);
    pending_readings.push_back(convert_code(word));
    requests_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [19:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rtdt_pkg::REG_RREF) ref_ohms = value[rtdt_pkg::RREF_W-1:0];
    else nom_ohms = value[rtdt_pkg::R0_W-1:0];
  endtask

  task automatic test_reset_defaults;
    logic [15:0] corners[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE,
                                16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
    foreach (corners[i]) send_request(corners[i]);
  endtask

  task automatic test_register_extremes;
    // huge ratio: invalid, saturated high, but for the zero code
    write_reg(rtdt_pkg::REG_RREF, 20'd1000000);
    write_reg(rtdt_pkg::REG_R0, 20'd1);
    send_request(16'hFFFF);
    send_request(16'h0002);
    send_request(16'h0000);
    // zero nominal taken as one
    write_reg(rtdt_pkg::REG_R0, 20'd0);
    send_request(16'h0002);
    send_request(16'h0001);
    // zero reference gives R = 0
    write_reg(rtdt_pkg::REG_RREF, 20'd0);
    send_request(16'hFFFF);
    // max nominal, upper data bits dropped on the narrow register
    write_reg(rtdt_pkg::REG_RREF, 20'hFFFFF);
    write_reg(rtdt_pkg::REG_R0, 20'hFFFFF);
    send_request(16'hFFFF);
    send_request(16'h1234);
    write_reg(rtdt_pkg::REG_R0, 20'd200000);
    send_request(16'hFFFF);
    send_request(16'h4000);
    // near the invalid boundary: x close to 8
    write_reg(rtdt_pkg::REG_RREF, 20'd80000);
    write_reg(rtdt_pkg::REG_R0, 20'd10000);
    send_request(16'hFFFF);
    send_request(16'hFFFD);
    write_reg(rtdt_pkg::REG_RREF, 20'd43000);
  endtask

  task automatic random_config;
    logic [19:0] rr;
    logic [19:0] r0;
    case ($urandom_range(3))
      0: begin
        rr = 20'($urandom_range(1, 1000000));
        r0 = 20'($urandom_range(1, 200000));
      end
      1: begin
        rr = 20'($urandom_range(20000, 43000));
        r0 = 20'($urandom_range(9000, 11000));
      end
      2: begin
        rr = 20'($urandom_range(300000, 450000));
        r0 = 20'($urandom_range(90000, 110000));
      end
      default: begin
        rr = 20'($urandom);
        r0 = 20'($urandom_range(1, 4000));
      end
    endcase
    write_reg(rtdt_pkg::REG_RREF, rr);
    write_reg(rtdt_pkg::REG_R0, r0);
  endtask

  task automatic test_random_phase(int idle_pct, int n_cfg);
    sender_idle_pct = idle_pct;
    repeat (n_cfg) begin
      random_config();
      repeat (160) send_request(16'($urandom));
    end
  endtask

  task automatic test_pause_until_empty;
    sender_idle_pct = 0;
    repeat (10) send_request(16'($urandom));
    drain();
    repeat (10) send_request(16'($urandom));
  endtask

  initial begin
    errors = 0;
    requests_sent = 0;
    readings_seen = 0;
    invalid_seen = 0;
    sender_idle_pct = 0;
    ref_ohms = 20'd43000;
    nom_ohms = 18'd10000;
    rst = 1'b1;
    start = 1'b0;
    rtd_register_word = '0;
    cfg_we = 1'b0;
    cfg_index = rtdt_pkg::REG_RREF;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_phase(10, 4);
    test_random_phase(74, 4);
    test_random_phase(0, 4);
    test_pause_until_empty();
    drain();

    $display("Sent %0d codes over random and corner register settings;", requests_sent);
    $display("checked %0d temperatures, %0d flagged out of range.",
             readings_seen, invalid_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rtdt_pkg.sv
rtl/rtdt_div.sv
rtl/rtdt_sqrt.sv
rtl/rtd_code_to_temperature.sv
tb/tb_rtd_code_to_temperature.sv
